>>> sv/sdi_pkg.sv
// sdi_pkg: beat types and mode codes for the sample delta integrator.
// No dependencies; used by every file under sv/.
package sdi_pkg;

	// Mode register codes
	localparam logic [3:0] MODE_BYTE_SINGLE   = 4'd0;
	localparam logic [3:0] MODE_BYTE_DOUBLE   = 4'd1;
	localparam logic [3:0] MODE_MONO_SINGLE   = 4'd2;
	localparam logic [3:0] MODE_MONO_DOUBLE   = 4'd3;
	localparam logic [3:0] MODE_STEREO_SINGLE = 4'd10;
	localparam logic [3:0] MODE_STEREO_DOUBLE = 4'd11;

	localparam int WORD_W = 16;
	localparam int MODE_W = 4;

	// Input beat
	typedef struct packed {
		logic [WORD_W-1:0] data_word;
		logic              first_word;
		logic              tail_word;
	} sdi_in_t;

	// Result beat
	typedef struct packed {
		logic [WORD_W-1:0] out_word;
		logic              mode_error;
	} sdi_out_t;

endpackage

>>> sv/sdi_core.sv
// sdi_core: integrator state and the single-pass decode of one beat.
// Depends on sdi_pkg.
module sdi_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  sdi_pkg::sdi_in_t          item,
	input  logic [sdi_pkg::MODE_W-1:0] mode,
	output sdi_pkg::sdi_out_t         result
);

	logic [1:0][15:0] first_sum_q;
	logic [1:0][15:0] second_sum_q;
	logic             toggle_q;

	logic [1:0][15:0] first_eff, second_eff, first_nxt, second_nxt;
	logic             toggle_eff, toggle_nxt;
	logic             mode_ok, dbl, is_byte, is_stereo, ch;
	logic [7:0]       hb, lb, s1_hi, s2_hi, s1_lo, s2_lo;
	logic [15:0]      fw, sw, w;

	// Mode decode
	always_comb begin
		unique case (mode)
			sdi_pkg::MODE_BYTE_SINGLE, sdi_pkg::MODE_BYTE_DOUBLE,
			sdi_pkg::MODE_MONO_SINGLE, sdi_pkg::MODE_MONO_DOUBLE,
			sdi_pkg::MODE_STEREO_SINGLE, sdi_pkg::MODE_STEREO_DOUBLE: mode_ok = 1'b1;
			default: mode_ok = 1'b0;
		endcase
	end

	assign dbl       = mode[0];
	assign is_byte   = (mode == sdi_pkg::MODE_BYTE_SINGLE) ||
	                   (mode == sdi_pkg::MODE_BYTE_DOUBLE);
	assign is_stereo = (mode == sdi_pkg::MODE_STEREO_SINGLE) ||
	                   (mode == sdi_pkg::MODE_STEREO_DOUBLE);

	// First word of a buffer sees cleared sums
	assign first_eff  = item.first_word ? '0 : first_sum_q;
	assign second_eff = item.first_word ? '0 : second_sum_q;
	assign toggle_eff = item.first_word ? 1'b0 : toggle_q;
	assign ch         = is_stereo & toggle_eff;

	assign w  = item.data_word;
	assign hb = w[15:8];
	assign lb = w[7:0];

	// Byte path: high byte then low byte through the cascade
	assign s1_hi = first_eff[0][7:0] + hb;
	assign s2_hi = second_eff[0][7:0] + s1_hi;
	assign s1_lo = s1_hi + lb;
	assign s2_lo = s2_hi + s1_lo;

	// Word path on the selected channel
	assign fw = first_eff[ch] + w;
	assign sw = second_eff[ch] + fw;

	// Result and next state
	always_comb begin
		first_nxt       = first_eff;
		second_nxt      = second_eff;
		toggle_nxt      = toggle_eff;
		result.out_word = w;
		result.mode_error = ~mode_ok;
		if (mode_ok && !item.tail_word) begin
			if (is_byte) begin
				first_nxt[0] = {8'h00, s1_lo};
				if (dbl) begin
					second_nxt[0]   = {8'h00, s2_lo};
					result.out_word = {s2_hi, s2_lo};
				end else begin
					result.out_word = {s1_hi, s1_lo};
				end
			end else begin
				first_nxt[ch] = fw;
				if (dbl) begin
					second_nxt[ch]  = sw;
					result.out_word = sw;
				end else begin
					result.out_word = fw;
				end
				if (is_stereo) begin
					toggle_nxt = ~toggle_eff;
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sum_q  <= '0;
			second_sum_q <= '0;
			toggle_q     <= 1'b0;
		end else if (fire) begin
			first_sum_q  <= first_nxt;
			second_sum_q <= second_nxt;
			toggle_q     <= toggle_nxt;
		end
	end

endmodule

>>> sv/sample_delta_integrator.sv
// sample_delta_integrator: top level, input register, result register, mode register.
// Depends on sdi_pkg and sdi_core.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | sdi_in_t  (data_word, first_word, tail_word)
//  out     | output    | out_valid/out_stall| sdi_out_t (out_word, mode_error)
//  cfg     | input     | cfg_wr_en          | cfg_wr_data (mode, 4 bits)
//
// One beat per cycle sustained while out_stall stays low; an accepted beat passes from the input
// register to the result register, where out_valid offers it.
// The decode of one beat is a chain of at most four short adders between the
// input register and the result register, and the sums update in the same cycle.
// Reset clears the sums, the channel toggle, the mode and both valid flags.
// in_stall rises only while both registers are full and out_stall is high.
module sample_delta_integrator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  sdi_pkg::sdi_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output sdi_pkg::sdi_out_t          out_data,
	input  logic                       cfg_wr_en,
	input  logic [sdi_pkg::MODE_W-1:0] cfg_wr_data
);

	logic                       valid_s1, valid_s2, advance, fire;
	sdi_pkg::sdi_in_t           item_s1;
	sdi_pkg::sdi_out_t          res_s2, res_comb;
	logic [sdi_pkg::MODE_W-1:0] mode_q;

	// Pipeline moves when the result register is free or being taken
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sdi_pkg::MODE_BYTE_SINGLE;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	sdi_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.mode   (mode_q),
		.result (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

>>> sv/sdi_checker.sv
// sdi_checker: port-level assertions for sample_delta_integrator, with its bind.
// Depends on sdi_pkg.
module sdi_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input sdi_pkg::sdi_out_t out_data
);

	// A stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result beat changed while stalled");

	// Input back-pressure only comes from a stalled, full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// Empty output means the input is open
	a_open_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output empty");

	// Accepted beat reaches the output while out_stall stays low
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_stall ##1 !out_stall |=> out_valid)
		else $error("accepted beat did not reach the output");

endmodule

bind sample_delta_integrator sdi_checker u_sdi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> sim/sdi_decode_monitor.sv
// sdi_decode_monitor: watches the beat channels of sample_delta_integrator, predicts each
// decoded word from its own running sums and compares it with the result beats.
// Depends on sdi_pkg.
`timescale 1ns / 100ps

module sdi_decode_monitor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  sdi_pkg::sdi_in_t           in_data,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  sdi_pkg::sdi_out_t          out_data,
	input  logic                       cfg_wr_en,
	input  logic [sdi_pkg::MODE_W-1:0] cfg_wr_data,
	output int                         fail_count,
	output int                         pending
);
	import sdi_pkg::*;

	// Predictor state: per-channel integrators, stereo toggle, mode register copy
	logic [WORD_W-1:0] stage1_sum [2];
	logic [WORD_W-1:0] stage2_sum [2];
	logic              chan_sel;
	logic [MODE_W-1:0] mode_q;

	sdi_out_t expected_words [$];
	int       errors;

	function automatic void clear_sums();
		stage1_sum[0] = '0;
		stage1_sum[1] = '0;
		stage2_sum[0] = '0;
		stage2_sum[1] = '0;
		chan_sel      = 1'b0;
	endfunction

	// 8-bit running sum on entry 0; stored back zero-extended
	function automatic logic [7:0] byte_sum(input logic [7:0] delta, input logic dbl);
		logic [7:0] s1;
		logic [7:0] s2;
		s1 = stage1_sum[0][7:0] + delta;
		stage1_sum[0] = {8'h00, s1};
		if (!dbl) begin
			return s1;
		end
		s2 = stage2_sum[0][7:0] + s1;
		stage2_sum[0] = {8'h00, s2};
		return s2;
	endfunction

	// 16-bit running sum on one channel
	function automatic logic [WORD_W-1:0] word_sum(input logic [WORD_W-1:0] delta,
		input logic ch, input logic dbl);
		logic [WORD_W-1:0] s1;
		s1 = stage1_sum[ch] + delta;
		stage1_sum[ch] = s1;
		if (!dbl) begin
			return s1;
		end
		stage2_sum[ch] = stage2_sum[ch] + s1;
		return stage2_sum[ch];
	endfunction

	// Expected result for one accepted input beat; advances the sums
	function automatic sdi_out_t decode_beat(input sdi_in_t b);
		sdi_out_t   r;
		logic       supported;
		logic [7:0] hi;
		logic [7:0] lo;
		case (mode_q)
			MODE_BYTE_SINGLE, MODE_BYTE_DOUBLE, MODE_MONO_SINGLE, MODE_MONO_DOUBLE,
			MODE_STEREO_SINGLE, MODE_STEREO_DOUBLE: supported = 1'b1;
			default: supported = 1'b0;
		endcase
		r.out_word   = b.data_word;
		r.mode_error = !supported;
		// clear happens even on tail words and unsupported modes
		if (b.first_word) begin
			clear_sums();
		end
		if (supported && !b.tail_word) begin
			case (mode_q)
				MODE_BYTE_SINGLE, MODE_BYTE_DOUBLE: begin
					hi = byte_sum(b.data_word[15:8], mode_q[0]);
					lo = byte_sum(b.data_word[7:0], mode_q[0]);
					r.out_word = {hi, lo};
				end
				MODE_MONO_SINGLE, MODE_MONO_DOUBLE: begin
					r.out_word = word_sum(b.data_word, 1'b0, mode_q[0]);
				end
				default: begin
					r.out_word = word_sum(b.data_word, chan_sel, mode_q[0]);
					chan_sel = ~chan_sel;
				end
			endcase
		end
		return r;
	endfunction

	// Sample both channels and the mode port on every edge
	always @(posedge clk or negedge arst_n) begin
		sdi_out_t exp_beat;
		if (!arst_n) begin
			clear_sums();
			mode_q = MODE_BYTE_SINGLE;
			expected_words.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_words.push_back(decode_beat(in_data));
			end
			if (cfg_wr_en) begin
				mode_q = cfg_wr_data;
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result beat word=%h err=%b", $time,
						out_data.out_word, out_data.mode_error);
					errors++;
				end else begin
					exp_beat = expected_words.pop_front();
					if (out_data.out_word !== exp_beat.out_word) begin
						$display("%0t: out_word expected %h actual %h", $time,
							exp_beat.out_word, out_data.out_word);
						errors++;
					end
					if (out_data.mode_error !== exp_beat.mode_error) begin
						$display("%0t: mode_error expected %b actual %b", $time,
							exp_beat.mode_error, out_data.mode_error);
						errors++;
					end
				end
			end
			fail_count <= errors;
			pending <= expected_words.size();
		end
	end

endmodule

>>> sim/sample_delta_integrator_tb.sv
// sample_delta_integrator_tb: clock, reset and beat stimulus for sample_delta_integrator,
// with sdi_decode_monitor beside the block doing all prediction and checking.
// Depends on sdi_pkg, sample_delta_integrator and sdi_decode_monitor.
`timescale 1ns / 100ps

module sample_delta_integrator_tb;
	import sdi_pkg::*;

	localparam int RANDOM_ITEMS = 1850;
	localparam int STALL_LIMIT  = 5000;

	// Unsupported mode codes used by the directed part
	localparam logic [MODE_W-1:0] MODE_UNUSED_TOP = 4'd15;
	localparam logic [MODE_W-1:0] MODE_UNUSED_GAP = 4'd4;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	sdi_in_t           in_data;
	logic              out_valid;
	logic              out_stall = 1'b0;
	sdi_out_t          out_data;
	logic              cfg_wr_en;
	logic [MODE_W-1:0] cfg_wr_data;

	int fail_count;
	int pending;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int quiet_cycles = 0;
	int items_sent = 0;

	logic [MODE_W-1:0] good_modes [6] = '{MODE_BYTE_SINGLE, MODE_BYTE_DOUBLE,
		MODE_MONO_SINGLE, MODE_MONO_DOUBLE, MODE_STEREO_SINGLE, MODE_STEREO_DOUBLE};

	always #5 clk = ~clk;

	sample_delta_integrator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	sdi_decode_monitor decode_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// Receiver back-pressure per current phase
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
	end

	// Watchdog: cycles with no beat accepted on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[sample_delta_integrator] ERROR");
			$finish;
		end
	end

	// Drive one input beat, with random idle cycles ahead of it; returns on accept
	task automatic send_beat(input logic [WORD_W-1:0] word, input logic first,
		input logic tail);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_word: word, first_word: first, tail_word: tail};
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Hold the sender off until every result beat has come, plus pipeline slack
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// One buffer: first word flagged, odd trailing word marked as tail; noisy flags otherwise
	task automatic send_buffer(input int n_words, input bit noisy);
		logic [WORD_W-1:0] word;
		logic              first;
		logic              tail;
		for (int i = 0; i < n_words; i++) begin
			case ($urandom_range(0, 7))
				0: word = 16'hFFFF;
				1: word = 16'h0000;
				2: word = 16'h8000;
				3: word = WORD_W'($urandom_range(0, 15));
				default: word = WORD_W'($urandom_range(0, 65535));
			endcase
			first = (i == 0);
			tail = (n_words % 2 == 1) && (i == n_words - 1);
			if (noisy) begin
				first = 1'($urandom_range(0, 1));
				tail = ($urandom_range(0, 3) == 0);
			end
			send_beat(word, first, tail);
			items_sent++;
		end
	endtask

	initial begin
		logic [MODE_W-1:0] m;
		int seg;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: byte single from the reset mode, including tail and first-on-tail
		send_beat(16'hFFFF, 1'b1, 1'b0);
		send_beat(16'h0180, 1'b0, 1'b0);
		send_beat(16'h7F01, 1'b0, 1'b0);
		send_beat(16'h1234, 1'b0, 1'b1);
		send_beat(16'h0000, 1'b1, 1'b1);
		send_beat(16'h00FF, 1'b0, 1'b0);
		write_mode(MODE_BYTE_DOUBLE);
		send_beat(16'h0102, 1'b1, 1'b0);
		send_beat(16'hFFFF, 1'b0, 1'b0);
		send_beat(16'h8000, 1'b0, 1'b0);
		// mono single starts mid-buffer from the byte sums
		write_mode(MODE_MONO_SINGLE);
		send_beat(16'hFFFF, 1'b0, 1'b0);
		send_beat(16'h0001, 1'b0, 1'b0);
		send_beat(16'h8000, 1'b0, 1'b0);
		write_mode(MODE_MONO_DOUBLE);
		send_beat(16'hFFFF, 1'b0, 1'b0);
		send_beat(16'h4321, 1'b0, 1'b1);
		write_mode(MODE_STEREO_SINGLE);
		send_beat(16'h1111, 1'b1, 1'b0);
		send_beat(16'hF000, 1'b0, 1'b0);
		send_beat(16'hABCD, 1'b0, 1'b1);
		send_beat(16'h0F00, 1'b0, 1'b0);
		write_mode(MODE_STEREO_DOUBLE);
		send_beat(16'h0001, 1'b1, 1'b0);
		send_beat(16'h0002, 1'b0, 1'b0);
		send_beat(16'hFFFF, 1'b0, 1'b0);
		// unsupported modes: clear on first word, then continue from cleared sums
		write_mode(MODE_UNUSED_TOP);
		send_beat(16'h5A5A, 1'b1, 1'b0);
		write_mode(MODE_UNUSED_GAP);
		send_beat(16'hA5A5, 1'b0, 1'b0);
		write_mode(MODE_STEREO_DOUBLE);
		send_beat(16'h0003, 1'b0, 1'b0);

		// Random buffers, cycling through the idling phases
		seg = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case (seg % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 54;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 54;
				end
				default: begin
					tx_idle_pct = 25;
					rx_stall_pct = 25;
				end
			endcase
			if ($urandom_range(0, 9) < 8) begin
				m = good_modes[$urandom_range(0, 5)];
			end else begin
				m = MODE_W'($urandom_range(0, 15));
			end
			write_mode(m);
			repeat ($urandom_range(2, 6)) begin
				send_buffer($urandom_range(1, 24), $urandom_range(0, 9) == 0);
			end
			seg++;
		end

		drain();
		if (fail_count == 0) begin
			$display("[sample_delta_integrator] OK");
		end else begin
			$display("[sample_delta_integrator] ERROR");
		end
		$finish;
	end

endmodule
